// ===== src/assert_macros.svh =====
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication through reset");

`endif

// ===== src/brl_pkg.sv =====
// Shared types and constants of the line rasterizer.
package brl_pkg;

   localparam int COORD_BITS  = 12;
   localparam int DEC_BITS    = COORD_BITS + 3;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DEC_BITS-1:0]   dec_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   // Classified request as it travels from the front end to the back end.
   typedef struct packed {
      op_type    op;
      coord_type start_x;
      coord_type start_y;
      coord_type final_x;
      coord_type delta_x;
      coord_type delta_y;
      logic      y_downward;
      dec_type   decision;
   } cmd_type;

endpackage

// ===== src/brl_req_if.sv =====
// Request channel: line start or pixel step.
interface brl_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   brl_pkg::coord_type x_start;
   brl_pkg::coord_type y_start;
   brl_pkg::coord_type x_finish;
   brl_pkg::coord_type y_finish;

   modport source (output valid, op, x_start, y_start, x_finish, y_finish, input ready);
   modport sink   (input valid, op, x_start, y_start, x_finish, y_finish, output ready);
endinterface

// ===== src/brl_rsp_if.sv =====
// Response channel: one rasterized pixel.
interface brl_rsp_if;
   logic               valid;
   logic               ready;
   brl_pkg::coord_type pixel_x;
   brl_pkg::coord_type pixel_y;
   logic               last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== src/brl_front.sv =====
// Front end: orders endpoints and sets up deltas and decision term for a start.
module brl_front (
   brl_req_if.sink             req_port,
   output logic                push_valid,
   input  logic                push_ready,
   output brl_pkg::cmd_type    push_data
);

   logic               swap;
   brl_pkg::coord_type dx;
   brl_pkg::coord_type dy;
   brl_pkg::coord_type first_y;
   brl_pkg::coord_type end_y;
   brl_pkg::dec_type   two_dy;
   brl_pkg::dec_type   dx_wide;

   assign req_port.ready = push_ready;
   assign push_valid     = req_port.valid;

   always_comb begin
      swap    = req_port.x_start > req_port.x_finish;
      dx      = swap ? (req_port.x_start - req_port.x_finish)
                     : (req_port.x_finish - req_port.x_start);
      dy      = (req_port.y_start >= req_port.y_finish)
                ? (req_port.y_start - req_port.y_finish)
                : (req_port.y_finish - req_port.y_start);
      first_y = swap ? req_port.y_finish : req_port.y_start;
      end_y   = swap ? req_port.y_start : req_port.y_finish;
      two_dy  = {2'b00, dy, 1'b0};
      dx_wide = {3'b000, dx};

      push_data.op         = brl_pkg::op_type'(req_port.op);
      push_data.start_x    = swap ? req_port.x_finish : req_port.x_start;
      push_data.start_y    = first_y;
      push_data.final_x    = swap ? req_port.x_start : req_port.x_finish;
      push_data.delta_x    = dx;
      push_data.delta_y    = dy;
      push_data.y_downward = end_y < first_y;
      push_data.decision   = two_dy - dx_wide;
   end

endmodule

// ===== src/brl_queue.sv =====
// Small FIFO of classified requests between front and back end.
module brl_queue #(
   parameter int DEPTH = brl_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  brl_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output brl_pkg::cmd_type pop_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   brl_pkg::cmd_type    entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/brl_back.sv =====
// Back end: line state, Bresenham step and the registered pixel output.
module brl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  brl_pkg::cmd_type pop_data,
   brl_rsp_if.source        rsp_port
);

   brl_pkg::coord_type cur_x_ff, cur_x_in;
   brl_pkg::coord_type cur_y_ff, cur_y_in;
   brl_pkg::coord_type final_x_ff, final_x_in;
   brl_pkg::coord_type delta_x_ff, delta_x_in;
   brl_pkg::coord_type delta_y_ff, delta_y_in;
   brl_pkg::dec_type   decision_ff, decision_in;
   logic               y_down_ff, y_down_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   brl_pkg::coord_type pixel_x_ff, pixel_x_in;
   brl_pkg::coord_type pixel_y_ff, pixel_y_in;
   logic               last_ff, last_in;
   logic               pop_fire;
   logic               at_end;
   brl_pkg::dec_type   two_dy;
   brl_pkg::dec_type   two_dx;

   // A start never needs the output register, so it may pass a stalled pixel.
   assign pop_ready = !rsp_valid_ff || rsp_port.ready || (pop_data.op == brl_pkg::OP_START);
   assign pop_fire  = pop_valid && pop_ready;

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.pixel_x    = pixel_x_ff;
   assign rsp_port.pixel_y    = pixel_y_ff;
   assign rsp_port.last_pixel = last_ff;

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      final_x_in   = final_x_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      decision_in  = decision_ff;
      y_down_in    = y_down_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      pixel_x_in   = pixel_x_ff;
      pixel_y_in   = pixel_y_ff;
      last_in      = last_ff;
      at_end       = cur_x_ff == final_x_ff;
      two_dy       = {2'b00, delta_y_ff, 1'b0};
      two_dx       = {2'b00, delta_x_ff, 1'b0};

      if (pop_fire) begin
         case (pop_data.op)
            brl_pkg::OP_START: begin
               cur_x_in    = pop_data.start_x;
               cur_y_in    = pop_data.start_y;
               final_x_in  = pop_data.final_x;
               delta_x_in  = pop_data.delta_x;
               delta_y_in  = pop_data.delta_y;
               decision_in = pop_data.decision;
               y_down_in   = pop_data.y_downward;
               busy_in     = 1'b1;
            end
            brl_pkg::OP_STEP: begin
               // A step while idle is dropped without a pixel.
               if (busy_ff) begin
                  rsp_valid_in = 1'b1;
                  pixel_x_in   = cur_x_ff;
                  pixel_y_in   = cur_y_ff;
                  last_in      = at_end;
                  if (at_end) begin
                     busy_in = 1'b0;
                  end else begin
                     cur_x_in = cur_x_ff + 1'b1;
                     if (decision_ff[brl_pkg::DEC_BITS-1]) begin
                        decision_in = decision_ff + two_dy;
                     end else begin
                        decision_in = decision_ff + two_dy - two_dx;
                        cur_y_in    = y_down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      final_x_ff  <= final_x_in;
      delta_x_ff  <= delta_x_in;
      delta_y_ff  <= delta_y_in;
      decision_ff <= decision_in;
      y_down_ff   <= y_down_in;
      pixel_x_ff  <= pixel_x_in;
      pixel_y_ff  <= pixel_y_in;
      last_ff     <= last_in;
   end

endmodule

// ===== src/bresenham_line_rasterizer.sv =====
// Top level of the x-major Bresenham line rasterizer.
//
//   channel   direction  carries
//   req_port  in         op (start or step), x_start, y_start, x_finish, y_finish
//   rsp_port  out        pixel_x, pixel_y, last_pixel
//
// One request per cycle is accepted while the request queue (QUEUE_DEPTH entries) has room.
// A step that yields a pixel is written into the queue when accepted, then into the output
// register of the stepping unit, from which it shows on rsp_port.
// A start and a step while idle yield no pixel; a start passes a stalled pixel.
// Reset is synchronous: queue empty, no line in progress, no pixel pending.
// A stalled rsp_port holds its pixel; the queue then fills and req_port.ready drops.
module bresenham_line_rasterizer #(
   parameter int QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   brl_req_if.sink   req_port,
   brl_rsp_if.source rsp_port
);

   logic             push_valid;
   logic             push_ready;
   brl_pkg::cmd_type push_data;
   logic             pop_valid;
   logic             pop_ready;
   brl_pkg::cmd_type pop_data;

   brl_front u_front (
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   brl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   brl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_port  (rsp_port)
   );

endmodule

// ===== src/brl_checker.sv =====
// Port-level checks of the line rasterizer and their bind to the top level.
`include "assert_macros.svh"

module brl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input brl_pkg::coord_type pixel_x,
   input brl_pkg::coord_type pixel_y,
   input logic               last_pixel
);

   // No pixel can be pending right after reset.
   `ASSERT_NEXT_ALWAYS(a_no_pixel_after_reset, clock, reset, !rsp_valid)

   // The request queue is empty after reset, so requests are taken at once.
   `ASSERT_NEXT_ALWAYS(a_ready_after_reset, clock, reset, req_ready)

   // A stalled pixel stays and holds its value.
   `ASSERT_NEXT(a_pixel_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))

endmodule

bind bresenham_line_rasterizer brl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .pixel_x    (rsp_port.pixel_x),
   .pixel_y    (rsp_port.pixel_y),
   .last_pixel (rsp_port.last_pixel)
);

// ===== tb/tb_top.sv =====
// Testbench of the line rasterizer: directed table, then random lines and single requests checked by a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAND_ITEMS  = 1350;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 8;
   localparam int TABLE_ROWS  = 25;

   typedef struct packed {
      brl_pkg::op_type    op;
      brl_pkg::coord_type xs;
      brl_pkg::coord_type ys;
      brl_pkg::coord_type xf;
      brl_pkg::coord_type yf;
   } request_type;

   typedef struct packed {
      brl_pkg::coord_type x;
      brl_pkg::coord_type y;
      logic               last;
   } pixel_type;

   // typed: expectation written in the row; has_pixel/px then give it
   typedef struct packed {
      request_type rq;
      logic        typed;
      logic        has_pixel;
      pixel_type   px;
   } row_type;

   localparam pixel_type NO_PX = '{12'd0, 12'd0, 1'b0};

   localparam row_type DIRECTED [TABLE_ROWS] = '{
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_START, 12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b1,
        '{12'd0, 12'd0, 1'b1}},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b1,
        '{12'd4095, 12'd4095, 1'b1}},
      '{'{brl_pkg::OP_START, 12'd100,  12'd0,    12'd100,  12'd4095}, 1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b1,
        '{12'd100, 12'd0, 1'b1}},
      '{'{brl_pkg::OP_START, 12'd4095, 12'd0,    12'd4092, 12'd3},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_START, 12'd0,    12'd0,    12'd4095, 12'd0},    1'b1, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, 1'b1,
        '{12'd0, 12'd0, 1'b0}},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      // restart while busy with a steep line
      '{'{brl_pkg::OP_START, 12'd10,   12'd4095, 12'd12,   12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_START, 12'd5,    12'd7,    12'd8,    12'd9},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX},
      '{'{brl_pkg::OP_STEP,  12'd0,    12'd0,    12'd0,    12'd0},    1'b0, 1'b0, NO_PX}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   brl_req_if req_bus();
   brl_rsp_if rsp_bus();

   bresenham_line_rasterizer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned errors         = 0;
   int unsigned counted        = 0;
   pixel_type   expected_pixels [$];

   // predictor state of the line in progress
   brl_pkg::coord_type tr_x, tr_y, tr_end_x, tr_dx, tr_dy;
   brl_pkg::dec_type   tr_err;
   logic               tr_down, tr_active;

   function automatic bit trace_step(input request_type rq, output pixel_type px);
      brl_pkg::coord_type end_y;
      px = NO_PX;
      if (rq.op == brl_pkg::OP_START) begin
         tr_dx = (rq.xs > rq.xf) ? rq.xs - rq.xf : rq.xf - rq.xs;
         tr_dy = (rq.ys > rq.yf) ? rq.ys - rq.yf : rq.yf - rq.ys;
         if (rq.xs > rq.xf) begin
            tr_x     = rq.xf;
            tr_y     = rq.yf;
            tr_end_x = rq.xs;
            end_y    = rq.ys;
         end else begin
            tr_x     = rq.xs;
            tr_y     = rq.ys;
            tr_end_x = rq.xf;
            end_y    = rq.yf;
         end
         tr_down   = end_y < tr_y;
         tr_err    = (brl_pkg::dec_type'(tr_dy) << 1) - brl_pkg::dec_type'(tr_dx);
         tr_active = 1'b1;
         return 1'b0;
      end
      if (!tr_active) return 1'b0;
      px.x    = tr_x;
      px.y    = tr_y;
      px.last = (tr_x == tr_end_x);
      if (px.last) begin
         tr_active = 1'b0;
         return 1'b1;
      end
      tr_x = tr_x + 1'b1;
      if (tr_err[brl_pkg::DEC_BITS-1]) begin
         tr_err = tr_err + (brl_pkg::dec_type'(tr_dy) << 1);
      end else begin
         tr_err = tr_err + (brl_pkg::dec_type'(tr_dy) << 1)
                  - (brl_pkg::dec_type'(tr_dx) << 1);
         tr_y   = tr_down ? tr_y - 1'b1 : tr_y + 1'b1;
      end
      return 1'b1;
   endfunction

   // holds the request until accepted; returns at the following falling edge
   task automatic send_request(input request_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= rq.op;
      req_bus.x_start  <= rq.xs;
      req_bus.y_start  <= rq.ys;
      req_bus.x_finish <= rq.xf;
      req_bus.y_finish <= rq.yf;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue(input request_type rq);
      pixel_type px;
      bit        has;
      send_request(rq);
      has = trace_step(rq, px);
      if (has) expected_pixels.push_back(px);
      counted++;
   endtask

   task automatic random_line();
      request_type rq;
      int dx, dy, x0, x1, y0, y1, steps, sel;
      sel = $urandom_range(99);
      if (sel < 80)      dx = $urandom_range(12);
      else if (sel < 98) dx = $urandom_range(60, 13);
      else               dx = $urandom_range(300, 100);
      if ($urandom_range(99) < 75) dy = $urandom_range(dx);
      else                         dy = $urandom_range(4095);
      x0 = $urandom_range(4095 - dx);
      x1 = x0 + dx;
      y0 = $urandom_range(4095);
      if ($urandom_range(1)) y1 = (y0 >= dy) ? y0 - dy : y0 + dy;
      else                   y1 = (y0 + dy <= 4095) ? y0 + dy : y0 - dy;
      if (y1 < 0 || y1 > 4095) y1 = $urandom_range(4095);
      rq.op = brl_pkg::OP_START;
      if ($urandom_range(1)) begin
         rq.xs = brl_pkg::coord_type'(x0); rq.ys = brl_pkg::coord_type'(y0);
         rq.xf = brl_pkg::coord_type'(x1); rq.yf = brl_pkg::coord_type'(y1);
      end else begin
         rq.xs = brl_pkg::coord_type'(x1); rq.ys = brl_pkg::coord_type'(y1);
         rq.xf = brl_pkg::coord_type'(x0); rq.yf = brl_pkg::coord_type'(y0);
      end
      issue(rq);
      steps = dx + 1;
      sel = $urandom_range(99);
      if (sel < 10)      steps = $urandom_range(dx);  // cut short, next start drops it
      else if (sel < 20) steps = steps + $urandom_range(3, 1);  // steps while idle
      rq.op = brl_pkg::OP_STEP;
      for (int i = 0; i < steps; i++) begin
         rq.xs = brl_pkg::coord_type'($urandom); rq.ys = brl_pkg::coord_type'($urandom);
         rq.xf = brl_pkg::coord_type'($urandom); rq.yf = brl_pkg::coord_type'($urandom);
         issue(rq);
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d last=%0b",
                   rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last_pixel);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.pixel_x !== want.x) begin
               $error("pixel_x: expected %0d, actual %0d", want.x, rsp_bus.pixel_x);
               errors++;
            end
            if (rsp_bus.pixel_y !== want.y) begin
               $error("pixel_y: expected %0d, actual %0d", want.y, rsp_bus.pixel_y);
               errors++;
            end
            if (rsp_bus.last_pixel !== want.last) begin
               $error("last_pixel: expected %0b, actual %0b", want.last, rsp_bus.last_pixel);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      request_type rq;
      pixel_type   px;
      bit          has;
      int          phase, waited;
      int unsigned send_pct [4] = '{0, 83, 0, 38};
      int unsigned stall_pct [4] = '{0, 0, 83, 38};

      req_bus.valid    = 1'b0;
      req_bus.op       = brl_pkg::OP_STEP;
      req_bus.x_start  = '0;
      req_bus.y_start  = '0;
      req_bus.x_finish = '0;
      req_bus.y_finish = '0;
      rsp_bus.ready    = 1'b0;
      tr_x = '0; tr_y = '0; tr_end_x = '0; tr_dx = '0; tr_dy = '0;
      tr_err = '0; tr_down = 1'b0; tr_active = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         send_request(DIRECTED[i].rq);
         has = trace_step(DIRECTED[i].rq, px);
         if (DIRECTED[i].typed) begin
            if (DIRECTED[i].has_pixel) expected_pixels.push_back(DIRECTED[i].px);
         end else if (has) begin
            expected_pixels.push_back(px);
         end
      end

      counted = 0;
      while (counted < RAND_ITEMS) begin
         phase = counted * 4 / RAND_ITEMS;
         if (phase > 3) phase = 3;
         send_idle_pct = send_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         if ($urandom_range(99) < 10) begin
            rq.op = brl_pkg::op_type'($urandom_range(1));
            rq.xs = brl_pkg::coord_type'($urandom); rq.ys = brl_pkg::coord_type'($urandom);
            rq.xf = brl_pkg::coord_type'($urandom); rq.yf = brl_pkg::coord_type'($urandom);
            issue(rq);
         end else begin
            random_line();
         end
      end
      req_bus.valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      waited = 0;
      while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", expected_pixels.size());
         errors++;
      end

      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== bresenham_line_rasterizer.f =====
+incdir+src
src/brl_pkg.sv
src/brl_req_if.sv
src/brl_rsp_if.sv
src/brl_front.sv
src/brl_queue.sv
src/brl_back.sv
src/bresenham_line_rasterizer.sv
src/brl_checker.sv
tb/tb_top.sv
